/* rtl/rfa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_pkg : shared types and constants of the reciprocal frequency averager
// Word layouts, status codes, register indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int FREQ_W     = 40;  // Q32.8 Hz
  localparam int PERIOD_W   = 32;
  localparam int REF_W      = 32;
  localparam int RATIO_W    = 8;
  localparam int CFG_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int FRAC_W     = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REF_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_RATIO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_FLOOR = 2'd2;

  // register reset values
  localparam logic [REF_W-1:0]   REF_COUNT_RST   = 32'd3840000000;
  localparam logic [RATIO_W-1:0] SPIKE_RATIO_RST = 8'd10;
  localparam logic [FREQ_W-1:0]  SPIKE_FLOOR_RST = 40'd256;

  // result status codes
  localparam logic [1:0] ST_HELD    = 2'd0;
  localparam logic [1:0] ST_NOSIG   = 2'd1;
  localparam logic [1:0] ST_SPIKE   = 2'd2;
  localparam logic [1:0] ST_UPDATED = 2'd3;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic                running;
    logic                panning;
    logic                frozen;
  } in_word_t;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic [1:0]        status;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV_INST,
    S_CHECK,
    S_AVG_START,
    S_DIV_AVG,
    S_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load_in;
    logic       clear;
    logic       start_inst;
    logic       cap_inst;
    logic       commit;
    logic       start_avg;
    logic       set_avg;
    logic       out_load;
    logic [1:0] res_code;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic inactive;
    logic no_signal;
    logic spike;
    logic div_done;
  } dp_stat_t;

endpackage

/* rtl/rfa_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_div : shared restoring divider
// One quotient bit per cycle; done pulses for one cycle once the last quotient
// bit is in, with the quotient valid. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module rfa_div #(
  parameter int DVD_W = 43,
  parameter int DVS_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             done_r;

  logic [DVS_W:0] trial;
  logic [DVS_W:0] diff;
  logic           ge;

  // trial subtract of the next partial remainder
  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  // iteration control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNT_W'(DVD_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder shift
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/rfa_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_dpath : datapath of the reciprocal frequency averager
// Configuration registers, input and output words, sample ring, running sum,
// fill count, spike test and the shared divider.
// ----------------------------------------------------------------------------
module rfa_dpath #(
  parameter int AVG_DEPTH = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [rfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rfa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  rfa_pkg::in_word_t                  in_word,
  input  rfa_pkg::ctrl_cmd_t                 cmd,
  output rfa_pkg::dp_stat_t                  stat,
  output rfa_pkg::out_word_t                 out_word
);

  localparam int FREQ_W = rfa_pkg::FREQ_W;
  localparam int SUM_W  = FREQ_W + $clog2(AVG_DEPTH);
  localparam int SLOT_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int FILL_W = $clog2(AVG_DEPTH + 1);
  localparam int PROD_W = FREQ_W + rfa_pkg::RATIO_W;

  logic [rfa_pkg::REF_W-1:0]   ref_r;
  logic [rfa_pkg::RATIO_W-1:0] ratio_r;
  logic [FREQ_W-1:0]           floor_r;

  rfa_pkg::in_word_t  in_r;
  rfa_pkg::out_word_t out_r;

  logic [FREQ_W-1:0] ring [AVG_DEPTH];
  logic [FREQ_W-1:0] ring_rd_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [SLOT_W-1:0] slot_r;
  logic [FILL_W-1:0] fill_r;
  logic [FREQ_W-1:0] avg_r;
  logic [FREQ_W-1:0] inst_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod;
  logic [FREQ_W-1:0] drop_val;

  logic [SUM_W-1:0]             div_dvd;
  logic [rfa_pkg::PERIOD_W-1:0] div_dvs;
  logic [SUM_W-1:0]             div_quo;
  logic                         div_done;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r   <= rfa_pkg::REF_COUNT_RST;
      ratio_r <= rfa_pkg::SPIKE_RATIO_RST;
      floor_r <= rfa_pkg::SPIKE_FLOOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rfa_pkg::CFG_REF_COUNT:   ref_r   <= cfg_data[rfa_pkg::REF_W-1:0];
        rfa_pkg::CFG_SPIKE_RATIO: ratio_r <= cfg_data[rfa_pkg::RATIO_W-1:0];
        rfa_pkg::CFG_SPIKE_FLOOR: floor_r <= cfg_data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // spike threshold, taken from the average held when the word arrives
  assign prod = PROD_W'(avg_r) * PROD_W'(ratio_r);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r   <= in_word;
      prod_r <= prod;
    end
  end

  // decode of the held word
  assign stat.inactive  = !(in_r.running && !in_r.panning && !in_r.frozen);
  assign stat.no_signal = (in_r.period == '0) || (in_r.period == '1);
  assign stat.spike     = (fill_r != '0) && (avg_r > floor_r) &&
                          ({{rfa_pkg::RATIO_W{1'b0}}, inst_r} > prod_r);
  assign stat.div_done  = div_done;

  // divider operand select: instant value or average
  always_comb begin
    if (cmd.start_avg) begin
      div_dvd = sum_r;
      div_dvs = rfa_pkg::PERIOD_W'(fill_r);
    end else begin
      div_dvd = SUM_W'({ref_r, {rfa_pkg::FRAC_W{1'b0}}});
      div_dvs = in_r.period;
    end
  end

  rfa_div #(
    .DVD_W (SUM_W),
    .DVS_W (rfa_pkg::PERIOD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start_inst | cmd.start_avg),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.cap_inst) begin
      inst_r <= div_quo[FREQ_W-1:0];
    end
  end

  // sample ring; the slot being replaced is read every cycle
  always_ff @(posedge clk) begin
    ring_rd_r <= ring[slot_r];
    if (cmd.commit) begin
      ring[slot_r] <= inst_r;
    end
  end

  // a slot beyond the fill count holds nothing since the last clear
  assign drop_val = (fill_r == FILL_W'(AVG_DEPTH)) ? ring_rd_r : '0;
  assign sum_nxt  = sum_r - SUM_W'(drop_val) + SUM_W'(inst_r);

  // averaging state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      sum_r  <= '0;
      slot_r <= '0;
      fill_r <= '0;
      avg_r  <= '0;
    end else begin
      if (cmd.commit) begin
        sum_r  <= sum_nxt;
        slot_r <= (slot_r == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        if (fill_r != FILL_W'(AVG_DEPTH)) begin
          fill_r <= fill_r + 1'b1;
        end
      end
      if (cmd.set_avg) begin
        avg_r <= div_quo[FREQ_W-1:0];
      end
    end
  end

  // result word; a cleared average already reads zero
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.frequency <= avg_r;
      out_r.status    <= cmd.res_code;
    end
  end

  assign out_word = out_r;

endmodule

/* rtl/rfa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_ctrl : controller of the reciprocal frequency averager
// Sequences one word through decode, up to two divisions and the ring update,
// and owns both handshakes.
// ----------------------------------------------------------------------------
module rfa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  rfa_pkg::dp_stat_t  stat,
  output rfa_pkg::ctrl_cmd_t cmd
);

  rfa_pkg::state_t state_r;
  rfa_pkg::state_t state_nxt;
  logic [1:0]      res_r;
  logic [1:0]      res_nxt;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rfa_pkg::S_IDLE: begin
        if (in_valid) state_nxt = rfa_pkg::S_DECODE;
      end
      rfa_pkg::S_DECODE: begin
        if (stat.inactive || stat.no_signal) state_nxt = rfa_pkg::S_RESULT;
        else                                 state_nxt = rfa_pkg::S_DIV_INST;
      end
      rfa_pkg::S_DIV_INST: begin
        if (stat.div_done) state_nxt = rfa_pkg::S_CHECK;
      end
      rfa_pkg::S_CHECK: begin
        if (stat.spike) state_nxt = rfa_pkg::S_RESULT;
        else            state_nxt = rfa_pkg::S_AVG_START;
      end
      rfa_pkg::S_AVG_START: state_nxt = rfa_pkg::S_DIV_AVG;
      rfa_pkg::S_DIV_AVG: begin
        if (stat.div_done) state_nxt = rfa_pkg::S_RESULT;
      end
      rfa_pkg::S_RESULT: begin
        if (out_free) state_nxt = rfa_pkg::S_IDLE;
      end
      default: state_nxt = rfa_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.res_code = res_r;
    res_nxt      = res_r;
    case (state_r)
      rfa_pkg::S_IDLE: cmd.load_in = in_valid;
      rfa_pkg::S_DECODE: begin
        if (stat.inactive) begin
          res_nxt = rfa_pkg::ST_HELD;
        end else if (stat.no_signal) begin
          cmd.clear = 1'b1;
          res_nxt   = rfa_pkg::ST_NOSIG;
        end else begin
          cmd.start_inst = 1'b1;
        end
      end
      rfa_pkg::S_DIV_INST: cmd.cap_inst = stat.div_done;
      rfa_pkg::S_CHECK: begin
        if (stat.spike) res_nxt    = rfa_pkg::ST_SPIKE;
        else            cmd.commit = 1'b1;
      end
      rfa_pkg::S_AVG_START: cmd.start_avg = 1'b1;
      rfa_pkg::S_DIV_AVG: begin
        if (stat.div_done) begin
          cmd.set_avg = 1'b1;
          res_nxt     = rfa_pkg::ST_UPDATED;
        end
      end
      rfa_pkg::S_RESULT: cmd.out_load = out_free;
      default: ;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)      out_valid_nxt = 1'b1;
    else if (!out_stall)   out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rfa_pkg::S_IDLE;
      res_r       <= rfa_pkg::ST_HELD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_r       <= res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != rfa_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* rtl/reciprocal_frequency_averager_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reciprocal_frequency_averager_top : reciprocal counter with moving average
// Instant frequency = reference_count * 256 / period in Q32.8 Hz, spike
// filter, ring of AVG_DEPTH samples and running-sum average.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  in      | input     | in_valid/in_stall   | period, running, panning, frozen
//  out     | output    | out_valid/out_stall | frequency, status
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// Inactive and no-signal words go from decode straight to the result; a
// spiked word passes decode, the instant division and the spike check; an
// accepted sample also passes the average division, both on the shared
// one-bit-per-cycle divider. One word is in flight at once; a result held
// by out_stall does not block the next acceptance, but the next result waits
// for it. No clearing pass after reset: the fill count masks unwritten slots.
// ----------------------------------------------------------------------------
module reciprocal_frequency_averager_top #(
  parameter int AVG_DEPTH = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rfa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rfa_pkg::in_word_t              in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rfa_pkg::out_word_t             out_word
);

  rfa_pkg::ctrl_cmd_t cmd;
  rfa_pkg::dp_stat_t  stat;

  rfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  rfa_dpath #(
    .AVG_DEPTH (AVG_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_word  (out_word)
  );

  // busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again while a word is in flight");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result register loaded while still stalled");

  // no-signal result reads zero
  a_nosig_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_word.status == rfa_pkg::ST_NOSIG) |-> (out_word.frequency == '0))
    else $error("no-signal result with nonzero frequency");

  // divider finishes only inside a word
  a_div_in_word: assert property (@(posedge clk) disable iff (!rst_n)
    stat.div_done |-> in_stall)
    else $error("divider done while idle");

endmodule
